[rtl/daf_pkg.sv]
// Shared types, codes, constants and helper functions of the datagram admission filter.
package daf_pkg;

	localparam int ENTRIES_DEF      = 32;
	localparam int MAX_DATAGRAM_DEF = 2048;
	localparam int QUEUE_DEPTH      = 4;
	localparam int COUNT_W          = 6;
	localparam int HEADER_BYTES     = 8;
	localparam int START_LEN        = 5;
	localparam int STOP_LEN         = 4;
	localparam logic [15:0] LEN_KEY  = 16'h2F2F;
	localparam logic [7:0]  PAD_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BYTE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		V_ACCEPTED   = 3'd0,
		V_DENIED     = 3'd1,
		V_CHECKSUM   = 3'd2,
		V_LENGTH     = 3'd3,
		V_UNKNOWN    = 3'd4,
		V_LOADED     = 3'd5,
		V_REJECTED   = 3'd6,
		V_CLEARED    = 3'd7
	} verdict_t;

	typedef struct packed {
		logic                is_byte;
		verdict_t            verdict;
		logic                hit;
		logic [7:0]          data_byte;
		logic                last;
		logic [COUNT_W-1:0]  count;
	} cmd_t;

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] start_char(input logic [2:0] p);
		logic [7:0] c;
		case (p)
			3'd0: c = 8'h73;
			3'd1: c = 8'h74;
			3'd2: c = 8'h61;
			3'd3: c = 8'h72;
			3'd4: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] stop_char(input logic [2:0] p);
		logic [7:0] c;
		case (p)
			3'd0: c = 8'h73;
			3'd1: c = 8'h74;
			3'd2: c = 8'h6F;
			3'd3: c = 8'h70;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/daf_if.sv]
// Handshake interfaces for the input item channel and the result channel.
interface daf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic [7:0]  data_byte;
	logic        last;

	modport source (output valid, op, address, prefix_len, data_byte, last, input ready);
	modport sink (input valid, op, address, prefix_len, data_byte, last, output ready);
endinterface

interface daf_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic       run_flag;
	logic [5:0] entry_count;

	modport source (output valid, verdict, run_flag, entry_count, input ready);
	modport sink (input valid, verdict, run_flag, entry_count, output ready);
endinterface

[rtl/daf_front.sv]
// Front end: prefix table, load and clear handling, source match per byte beat.
module daf_front #(
	parameter int ENTRIES = daf_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	daf_in_if.sink         item,
	output daf_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [31:0]             value_q [ENTRIES];
	logic [31:0]             mask_q [ENTRIES];
	logic [CNT_W-1:0]        used_count_q;
	logic [CNT_W-1:0]        used_count_d;
	logic [CNT_W+5:0]        count_wide;
	logic [ENTRIES-1:0]      hits;
	logic                    accept;
	logic                    load_ok;
	logic                    keep;
	logic [31:0]             new_mask;
	daf_pkg::verdict_t       verdict_d;

	logic                    valid_s1;
	logic                    is_byte_s1;
	daf_pkg::verdict_t       verdict_s1;
	logic [ENTRIES-1:0]      hits_s1;
	logic [7:0]              data_s1;
	logic                    last_s1;
	logic [5:0]              count_s1;

	assign item.ready = !valid_s1 || cmd_ready;
	assign accept     = item.valid && item.ready;
	assign load_ok    = (item.prefix_len >= 6'd1) && (item.prefix_len <= 6'd32)
		&& (used_count_q < CNT_W'(ENTRIES));
	assign new_mask   = ~(32'hFFFF_FFFF >> item.prefix_len);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hits[i] = (CNT_W'(i) < used_count_q)
				&& ((item.address & mask_q[i]) == value_q[i]);
		end
	end

	always_comb begin
		used_count_d = used_count_q;
		verdict_d    = daf_pkg::V_ACCEPTED;
		keep         = 1'b1;
		case (item.op)
			daf_pkg::OP_LOAD: begin
				if (load_ok) begin
					used_count_d = used_count_q + CNT_W'(1);
					verdict_d    = daf_pkg::V_LOADED;
				end else begin
					verdict_d    = daf_pkg::V_REJECTED;
				end
			end
			daf_pkg::OP_CLEAR: begin
				used_count_d = '0;
				verdict_d    = daf_pkg::V_CLEARED;
			end
			daf_pkg::OP_BYTE: begin
				verdict_d    = daf_pkg::V_ACCEPTED;
			end
			default: begin
				keep         = 1'b0;
			end
		endcase
	end

	assign count_wide = {6'd0, used_count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			used_count_q <= '0;
		end else begin
			if (item.ready) begin
				valid_s1 <= accept && keep;
			end
			if (accept) begin
				used_count_q <= used_count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == daf_pkg::OP_LOAD && load_ok) begin
			value_q[used_count_q[IDX_W-1:0]] <= item.address & new_mask;
			mask_q[used_count_q[IDX_W-1:0]]  <= new_mask;
		end
		if (item.ready) begin
			is_byte_s1 <= (item.op == daf_pkg::OP_BYTE);
			verdict_s1 <= verdict_d;
			hits_s1    <= hits;
			data_s1    <= item.data_byte;
			last_s1    <= item.last;
			count_s1   <= count_wide[5:0];
		end
	end

	assign cmd_valid     = valid_s1;
	assign cmd.is_byte   = is_byte_s1;
	assign cmd.verdict   = verdict_s1;
	assign cmd.hit       = |hits_s1;
	assign cmd.data_byte = data_s1;
	assign cmd.last      = last_s1;
	assign cmd.count     = count_s1;

endmodule

[rtl/daf_queue.sv]
// Short command queue between the front end and the back end.
module daf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  daf_pkg::cmd_t  in_cmd,
	input  logic           in_valid,
	output logic           in_ready,
	output daf_pkg::cmd_t  out_cmd,
	output logic           out_valid,
	input  logic           out_ready
);
	localparam int PTR_W = $clog2(daf_pkg::QUEUE_DEPTH);

	daf_pkg::cmd_t   mem_q [daf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = (fill_q != (PTR_W + 1)'(daf_pkg::QUEUE_DEPTH));
	assign out_valid = (fill_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[rtl/daf_back.sv]
// Back end: datagram checks, run flag and the registered result beat.
module daf_back #(
	parameter int MAX_DATAGRAM = daf_pkg::MAX_DATAGRAM_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  daf_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	daf_out_if.source      result
);
	localparam int BI_W = $clog2(MAX_DATAGRAM + 1);

	logic [BI_W-1:0]   byte_index_q;
	logic [15:0]       xor_sum_q;
	logic [7:0]        pending_low_q;
	logic [15:0]       length_word_q;
	logic [15:0]       type_word_q;
	logic              start_ok_q;
	logic              stop_ok_q;
	logic              src_ok_q;
	logic              running_q;

	logic              out_valid_q;
	daf_pkg::verdict_t verdict_q;
	logic              run_q;
	logic [5:0]        count_q;

	logic              pop;
	logic              take;
	logic [BI_W-1:0]   k;
	logic [BI_W-1:0]   pk;
	logic [7:0]        fc;
	logic [BI_W-1:0]   n_d;
	logic [15:0]       xor_d;
	logic [7:0]        pending_d;
	logic [15:0]       length_d;
	logic [15:0]       type_d;
	logic              start_ok_d;
	logic              stop_ok_d;
	logic              src_ok_d;
	logic [15:0]       sum;
	daf_pkg::verdict_t judge;
	logic              running_d;

	assign cmd_ready = !out_valid_q || result.ready;
	assign pop       = cmd_valid && cmd_ready;

	assign k    = byte_index_q;
	assign take = (byte_index_q < BI_W'(MAX_DATAGRAM));
	assign pk   = k - BI_W'(daf_pkg::HEADER_BYTES);
	assign fc   = daf_pkg::fold_case(cmd.data_byte);

	always_comb begin
		n_d        = k;
		xor_d      = xor_sum_q;
		pending_d  = pending_low_q;
		length_d   = length_word_q;
		type_d     = type_word_q;
		start_ok_d = start_ok_q;
		stop_ok_d  = stop_ok_q;
		src_ok_d   = src_ok_q;
		if (take) begin
			n_d = k + BI_W'(1);
			if (k == '0) begin
				src_ok_d = cmd.hit;
			end
			if (k[0]) begin
				xor_d = xor_sum_q ^ {cmd.data_byte, pending_low_q};
			end else begin
				pending_d = cmd.data_byte;
			end
			if (k == BI_W'(2)) begin
				length_d[7:0] = cmd.data_byte;
			end
			if (k == BI_W'(3)) begin
				length_d[15:8] = cmd.data_byte;
			end
			if (k == BI_W'(4)) begin
				type_d[7:0] = cmd.data_byte;
			end
			if (k == BI_W'(5)) begin
				type_d[15:8] = cmd.data_byte;
			end
			if (k >= BI_W'(daf_pkg::HEADER_BYTES)) begin
				if (pk >= BI_W'(daf_pkg::START_LEN) || fc != daf_pkg::start_char(pk[2:0])) begin
					start_ok_d = 1'b0;
				end
				if (pk >= BI_W'(daf_pkg::STOP_LEN) || fc != daf_pkg::stop_char(pk[2:0])) begin
					stop_ok_d = 1'b0;
				end
			end
		end
	end

	always_comb begin
		sum       = n_d[0] ? (xor_d ^ {daf_pkg::PAD_BYTE, pending_d}) : xor_d;
		running_d = running_q;
		if (!src_ok_d) begin
			judge = daf_pkg::V_DENIED;
		end else if (sum != 16'd0) begin
			judge = daf_pkg::V_CHECKSUM;
		end else if ((length_d ^ daf_pkg::LEN_KEY) != {{(16 - BI_W){1'b0}}, n_d}) begin
			judge = daf_pkg::V_LENGTH;
		end else if (n_d < BI_W'(daf_pkg::HEADER_BYTES) || type_d != 16'd0) begin
			judge = daf_pkg::V_UNKNOWN;
		end else if (n_d == BI_W'(daf_pkg::HEADER_BYTES + daf_pkg::START_LEN) && start_ok_d) begin
			judge     = daf_pkg::V_ACCEPTED;
			running_d = 1'b1;
		end else if (n_d == BI_W'(daf_pkg::HEADER_BYTES + daf_pkg::STOP_LEN) && stop_ok_d) begin
			judge     = daf_pkg::V_ACCEPTED;
			running_d = 1'b0;
		end else begin
			judge = daf_pkg::V_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			xor_sum_q     <= '0;
			pending_low_q <= '0;
			length_word_q <= '0;
			type_word_q   <= '0;
			start_ok_q    <= 1'b1;
			stop_ok_q     <= 1'b1;
			src_ok_q      <= 1'b0;
			running_q     <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (!cmd.is_byte) begin
					out_valid_q <= 1'b1;
				end else if (cmd.last) begin
					out_valid_q   <= 1'b1;
					running_q     <= running_d;
					byte_index_q  <= '0;
					xor_sum_q     <= '0;
					pending_low_q <= '0;
					length_word_q <= '0;
					type_word_q   <= '0;
					start_ok_q    <= 1'b1;
					stop_ok_q     <= 1'b1;
					src_ok_q      <= 1'b0;
				end else begin
					byte_index_q  <= n_d;
					xor_sum_q     <= xor_d;
					pending_low_q <= pending_d;
					length_word_q <= length_d;
					type_word_q   <= type_d;
					start_ok_q    <= start_ok_d;
					stop_ok_q     <= stop_ok_d;
					src_ok_q      <= src_ok_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= cmd.is_byte ? judge : cmd.verdict;
			run_q     <= (cmd.is_byte && cmd.last) ? running_d : running_q;
			count_q   <= cmd.count;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.verdict     = verdict_q;
	assign result.run_flag    = run_q;
	assign result.entry_count = count_q;

endmodule

[rtl/datagram_admission_filter.sv]
// Top level of the datagram admission filter: front end, command queue and back end.
//
// Items arrive on the item channel, one per beat: a prefix load, a datagram
// byte or a table clear. Loads and clears give one result beat each; a
// datagram gives one result beat on its byte marked last, other bytes none.
// The result beat carries the verdict, the run flag and the entry count.
// One item is taken every cycle while the queue has room. A result passes
// from its item through the front register, where the source is compared
// against all table entries at once, the queue and the output register. The
// front end stalls only when the four-entry queue is full, and the back end
// only when the result register holds a beat that the receiver has not
// taken; a stalled receiver therefore lets items in until a result beat fills
// the result register, and up to five more, before the item channel drops
// ready. Reset empties the table, the queue and the result register, sets
// the run flag and clears any datagram in progress; no clearing pass runs.
module datagram_admission_filter #(
	parameter int ENTRIES      = daf_pkg::ENTRIES_DEF,
	parameter int MAX_DATAGRAM = daf_pkg::MAX_DATAGRAM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	daf_in_if.sink     item,
	daf_out_if.source  result
);
	daf_pkg::cmd_t front_cmd;
	logic          front_valid;
	logic          front_ready;
	daf_pkg::cmd_t back_cmd;
	logic          back_valid;
	logic          back_ready;

	daf_front #(
		.ENTRIES(ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	daf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (front_cmd),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_cmd   (back_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready)
	);

	daf_back #(
		.MAX_DATAGRAM(MAX_DATAGRAM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.result    (result)
	);

endmodule
